[design/qmfs_pkg.sv]
// ============================================================================
// qmfs_pkg
// Shared types and constants of the four-band QMF synthesis bank.
// ============================================================================
package qmfs_pkg;

    localparam int FUNC_BITS  = 2;
    localparam int INDEX_BITS = 5;
    localparam int SCALE_BITS = 16;
    localparam int SCALE_FRAC = 14;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd16384;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_PROC  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WR_SUM,
        ST_WR_DIFF,
        ST_MAC,
        ST_DRAIN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
    } lane_ctl_t;

endpackage

[design/qmfs_ram.sv]
// ============================================================================
// qmfs_ram
// Generic RAM with one write port and two registered read ports.
// ============================================================================
module qmfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 48
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

[design/qmfs_lane.sv]
// ============================================================================
// qmfs_lane
// One multiply-accumulate lane of the polyphase dot product.
// ============================================================================
module qmfs_lane #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18,
    parameter int ACC_W       = 48
) (
    input  logic                          aclk,
    input  qmfs_pkg::lane_ctl_t           ctl,
    input  logic signed [COEF_BITS-1:0]   coef,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [ACC_W-1:0]       acc
);

    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= coef * sample;
        end
        if (ctl.clr) begin
            acc_reg <= '0;
        end else if (ctl.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

[design/qmfs_merge.sv]
// ============================================================================
// qmfs_merge
// Rounds and saturates the two lane sums into the stage outputs.
// ============================================================================
module qmfs_merge #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18,
    parameter int ACC_W       = 48
) (
    input  logic signed [ACC_W-1:0]       acc_even,
    input  logic signed [ACC_W-1:0]       acc_odd,
    output logic signed [SAMPLE_BITS-1:0] first,
    output logic signed [SAMPLE_BITS-1:0] second
);

    localparam int SH = COEF_BITS - 1;

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [ACC_W:0] r;
        logic signed [ACC_W:0] s;
        logic                  same;
        r = {a[ACC_W-1], a} + (ACC_W+1)'(1 << (SH - 1));
        s = r >>> SH;
        same = (&s[ACC_W:SAMPLE_BITS-1]) | ~(|s[ACC_W:SAMPLE_BITS-1]);
        if (same) begin
            round_sat = s[SAMPLE_BITS-1:0];
        end else begin
            round_sat = {s[ACC_W], {(SAMPLE_BITS-1){~s[ACC_W]}}};
        end
    endfunction

    assign first  = round_sat(acc_odd);
    assign second = round_sat(acc_even);

endmodule

[design/four_band_qmf_synthesis.sv]
// ============================================================================
// four_band_qmf_synthesis
// Four-band tree QMF synthesis bank with two parallel MAC lanes.
// ============================================================================
// The s_ channel takes one beat per command; s_tuser selects the command.
// A load beat writes a scaled half-coefficient, a clear beat empties the
// three filter histories, and a process beat takes four subband samples and
// returns one m_ beat with four full-rate samples in time order.
// The cfg_ channel writes the coefficient gain and is always ready.
// A process beat runs four filter stages one after another; in each
// stage the even-tap and odd-tap lanes step through the history
// RAM one tap pair per cycle.
// Only one command is in work at a time; s_tready is high while idle.
// The result sits in an output register, so the next command is taken while
// it waits; a stalled receiver holds the block only at the end of the next
// process beat. Reset zeroes coefficients and histories through valid bits
// and restores the gain to 1.0; no clearing pass is needed.
// ============================================================================
module four_band_qmf_synthesis #(
    parameter int HALF_TAPS   = 24,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // coef_index, coef_value, band0, band1, band2, band3, zero fill
    input  logic [((qmfs_pkg::INDEX_BITS+COEF_BITS+4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // func
    input  logic [qmfs_pkg::FUNC_BITS-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // out_first, out_second, out_third, out_fourth, zero fill
    output logic [((4*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [qmfs_pkg::SCALE_BITS-1:0] cfg_data
);

    localparam int N      = 2 * HALF_TAPS;
    localparam int HW     = $clog2(N);
    localparam int JW     = $clog2(HALF_TAPS);
    localparam int ACC_W  = COEF_BITS + SAMPLE_BITS + JW + 1;
    localparam int PW     = COEF_BITS + qmfs_pkg::SCALE_BITS + 1;
    localparam int OUT_W  = ((4*SAMPLE_BITS+7)/8)*8;
    localparam int IB     = qmfs_pkg::INDEX_BITS;
    localparam int SB     = SAMPLE_BITS;

    qmfs_pkg::state_t state_reg, state_next;

    logic [qmfs_pkg::SCALE_BITS-1:0] scale_reg;
    logic [1:0]                      stage_reg;
    logic [JW-1:0]                   j_reg;
    logic [HW-1:0]                   head_reg [3];
    logic [N-1:0]                    hvld_reg [3];
    logic [HALF_TAPS-1:0]            cvld_reg;
    logic                            d1_reg, d2_reg;
    logic                            hv0_reg, hv1_reg, cv0_reg, cv1_reg;
    logic                            m_tvalid_reg;
    logic signed [PW-1:0]            prod_reg;
    logic [JW-1:0]                   cidx_reg;
    logic signed [SB-1:0]            b0_reg, b1_reg, b2_reg, b3_reg;
    logic signed [SB-1:0]            a0_reg, a1_reg, c0_reg, c1_reg;
    logic [OUT_W-1:0]                m_tdata_reg;

    logic                            s_acc;
    qmfs_pkg::func_t                 func_w;
    logic [IB-1:0]                   idx_w;
    logic signed [COEF_BITS-1:0]     cval_w;
    logic                            idx_ok;
    logic [1:0]                      sel_w;
    logic signed [SB-1:0]            low_w, high_w;
    logic signed [SB:0]              sum_w, diff_w;
    logic signed [SB-1:0]            sum_sat, diff_sat, hwdata;
    logic                            hist_we, coef_we, issue, out_free, fin_last;
    logic [HW-1:0]                   head_inc;
    logic [HW-1:0]                   k0, k1, ha0, ha1;
    logic [HW:0]                     hs0, hs1;
    logic [JW-1:0]                   ca0, ca1;
    logic signed [PW:0]              lr_w, ls_w;
    logic signed [COEF_BITS-1:0]     coef_wdata;
    logic [SB-1:0]                   hrd0 [3];
    logic [SB-1:0]                   hrd1 [3];
    logic [COEF_BITS-1:0]            crd0, crd1;
    logic signed [SB-1:0]            samp0, samp1;
    logic signed [COEF_BITS-1:0]     coef0, coef1;
    logic signed [ACC_W-1:0]         acc_even, acc_odd;
    logic signed [SB-1:0]            first_w, second_w;
    qmfs_pkg::lane_ctl_t             lane_ctl;

    assign func_w = qmfs_pkg::func_t'(s_tuser);
    assign idx_w  = s_tdata[IB-1:0];
    assign cval_w = s_tdata[IB+COEF_BITS-1:IB];
    assign idx_ok = (32'(idx_w) < HALF_TAPS);
    assign s_tready  = (state_reg == qmfs_pkg::ST_IDLE);
    assign s_acc     = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        case (stage_reg)
            2'd0:    sel_w = 2'd0;
            2'd1:    sel_w = 2'd1;
            default: sel_w = 2'd2;
        endcase
    end

    always_comb begin
        case (stage_reg)
            2'd0: begin
                low_w = b0_reg;
                high_w = b1_reg;
            end
            2'd1: begin
                low_w = b3_reg;
                high_w = b2_reg;
            end
            2'd2: begin
                low_w = a0_reg;
                high_w = c0_reg;
            end
            default: begin
                low_w = a1_reg;
                high_w = c1_reg;
            end
        endcase
    end

    assign sum_w  = {low_w[SB-1], low_w} + {high_w[SB-1], high_w};
    assign diff_w = {low_w[SB-1], low_w} - {high_w[SB-1], high_w};
    assign sum_sat = (sum_w[SB] != sum_w[SB-1]) ?
        {sum_w[SB], {(SB-1){~sum_w[SB]}}} : sum_w[SB-1:0];
    assign diff_sat = (diff_w[SB] != diff_w[SB-1]) ?
        {diff_w[SB], {(SB-1){~diff_w[SB]}}} : diff_w[SB-1:0];

    assign head_inc = (32'(head_reg[sel_w]) == N - 1) ? '0 : head_reg[sel_w] + 1'b1;

    // Tap k pairs coefficient c[k] with history entry (head + k) mod N.
    assign k0  = {j_reg, 1'b0};
    assign k1  = {j_reg, 1'b1};
    assign hs0 = {1'b0, head_reg[sel_w]} + {1'b0, k0};
    assign hs1 = {1'b0, head_reg[sel_w]} + {1'b0, k1};
    assign ha0 = (32'(hs0) >= N) ? HW'(32'(hs0) - N) : hs0[HW-1:0];
    assign ha1 = (32'(hs1) >= N) ? HW'(32'(hs1) - N) : hs1[HW-1:0];
    assign ca0 = (32'(k0) < HALF_TAPS) ? k0[JW-1:0] : JW'(N - 1 - 32'(k0));
    assign ca1 = (32'(k1) < HALF_TAPS) ? k1[JW-1:0] : JW'(N - 1 - 32'(k1));

    assign lr_w = {prod_reg[PW-1], prod_reg} + (PW+1)'(1 << (qmfs_pkg::SCALE_FRAC - 1));
    assign ls_w = lr_w >>> qmfs_pkg::SCALE_FRAC;
    assign coef_wdata = ((&ls_w[PW:COEF_BITS-1]) | ~(|ls_w[PW:COEF_BITS-1])) ?
        ls_w[COEF_BITS-1:0] : {ls_w[PW], {(COEF_BITS-1){~ls_w[PW]}}};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qmfs_pkg::ST_IDLE: begin
                if (s_acc && func_w == qmfs_pkg::FUNC_PROC) begin
                    state_next = qmfs_pkg::ST_WR_SUM;
                end else if (s_acc && func_w == qmfs_pkg::FUNC_LOAD && idx_ok) begin
                    state_next = qmfs_pkg::ST_LOAD;
                end
            end
            qmfs_pkg::ST_LOAD:    state_next = qmfs_pkg::ST_IDLE;
            qmfs_pkg::ST_WR_SUM:  state_next = qmfs_pkg::ST_WR_DIFF;
            qmfs_pkg::ST_WR_DIFF: state_next = qmfs_pkg::ST_MAC;
            qmfs_pkg::ST_MAC: begin
                if (32'(j_reg) == HALF_TAPS - 1) begin
                    state_next = qmfs_pkg::ST_DRAIN;
                end
            end
            qmfs_pkg::ST_DRAIN: begin
                if (!d1_reg && !d2_reg) begin
                    state_next = qmfs_pkg::ST_FIN;
                end
            end
            qmfs_pkg::ST_FIN: begin
                if (stage_reg != 2'd3) begin
                    state_next = qmfs_pkg::ST_WR_SUM;
                end else if (out_free) begin
                    state_next = qmfs_pkg::ST_IDLE;
                end
            end
            default: state_next = qmfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        hist_we = 1'b0;
        coef_we = 1'b0;
        issue = 1'b0;
        fin_last = 1'b0;
        hwdata = sum_sat;
        case (state_reg)
            qmfs_pkg::ST_LOAD: coef_we = 1'b1;
            qmfs_pkg::ST_WR_SUM: begin
                hist_we = 1'b1;
                hwdata = sum_sat;
            end
            qmfs_pkg::ST_WR_DIFF: begin
                hist_we = 1'b1;
                hwdata = diff_sat;
            end
            qmfs_pkg::ST_MAC: issue = 1'b1;
            qmfs_pkg::ST_FIN: fin_last = (stage_reg == 2'd3) && out_free;
            default: begin
                hist_we = 1'b0;
            end
        endcase
    end

    assign lane_ctl.clr    = (state_reg == qmfs_pkg::ST_WR_SUM);
    assign lane_ctl.mul_en = d1_reg;
    assign lane_ctl.acc_en = d2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= qmfs_pkg::ST_IDLE;
            scale_reg    <= qmfs_pkg::SCALE_RESET;
            stage_reg    <= '0;
            j_reg        <= '0;
            cvld_reg     <= '0;
            d1_reg       <= 1'b0;
            d2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int b = 0; b < 3; b++) begin
                head_reg[b] <= '0;
                hvld_reg[b] <= '0;
            end
        end else begin
            state_reg <= state_next;
            d1_reg <= issue;
            d2_reg <= d1_reg;
            if (cfg_valid) begin
                scale_reg <= cfg_data;
            end
            if (s_acc && func_w == qmfs_pkg::FUNC_CLEAR) begin
                for (int b = 0; b < 3; b++) begin
                    head_reg[b] <= '0;
                    hvld_reg[b] <= '0;
                end
            end
            if (s_acc) begin
                stage_reg <= '0;
            end else if (state_reg == qmfs_pkg::ST_FIN && stage_reg != 2'd3) begin
                stage_reg <= stage_reg + 2'd1;
            end
            if (coef_we) begin
                cvld_reg[cidx_reg] <= 1'b1;
            end
            if (hist_we) begin
                hvld_reg[sel_w][head_reg[sel_w]] <= 1'b1;
                head_reg[sel_w] <= head_inc;
            end
            if (state_reg == qmfs_pkg::ST_WR_DIFF) begin
                j_reg <= '0;
            end else if (issue) begin
                j_reg <= j_reg + 1'b1;
            end
            if (fin_last) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            prod_reg <= cval_w * $signed({1'b0, scale_reg});
            cidx_reg <= JW'(idx_w);
            b0_reg <= s_tdata[IB+COEF_BITS+SB-1:IB+COEF_BITS];
            b1_reg <= s_tdata[IB+COEF_BITS+2*SB-1:IB+COEF_BITS+SB];
            b2_reg <= s_tdata[IB+COEF_BITS+3*SB-1:IB+COEF_BITS+2*SB];
            b3_reg <= s_tdata[IB+COEF_BITS+4*SB-1:IB+COEF_BITS+3*SB];
        end
        hv0_reg <= hvld_reg[sel_w][ha0];
        hv1_reg <= hvld_reg[sel_w][ha1];
        cv0_reg <= cvld_reg[ca0];
        cv1_reg <= cvld_reg[ca1];
        if (state_reg == qmfs_pkg::ST_FIN) begin
            case (stage_reg)
                2'd0: begin
                    a0_reg <= first_w;
                    a1_reg <= second_w;
                end
                2'd1: begin
                    c0_reg <= first_w;
                    c1_reg <= second_w;
                end
                2'd2: begin
                    a0_reg <= first_w;
                    c0_reg <= second_w;
                end
                default: begin
                    if (out_free) begin
                        m_tdata_reg <= OUT_W'({second_w, first_w, c0_reg, a0_reg});
                    end
                end
            endcase
        end
    end

    for (genvar b = 0; b < 3; b++) begin : g_hist
        qmfs_ram #(
            .WIDTH(SB),
            .DEPTH(N)
        ) u_hist (
            .aclk  (aclk),
            .we    (hist_we && sel_w == 2'(b)),
            .waddr (head_reg[sel_w]),
            .wdata (hwdata),
            .raddr0(ha0),
            .raddr1(ha1),
            .rdata0(hrd0[b]),
            .rdata1(hrd1[b])
        );
    end

    qmfs_ram #(
        .WIDTH(COEF_BITS),
        .DEPTH(HALF_TAPS)
    ) u_coef (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (cidx_reg),
        .wdata (coef_wdata),
        .raddr0(ca0),
        .raddr1(ca1),
        .rdata0(crd0),
        .rdata1(crd1)
    );

    assign samp0 = hv0_reg ? $signed(hrd0[sel_w]) : '0;
    assign samp1 = hv1_reg ? $signed(hrd1[sel_w]) : '0;
    assign coef0 = cv0_reg ? $signed(crd0) : '0;
    assign coef1 = cv1_reg ? $signed(crd1) : '0;

    qmfs_lane #(
        .SAMPLE_BITS(SB),
        .COEF_BITS  (COEF_BITS),
        .ACC_W      (ACC_W)
    ) u_lane_even (
        .aclk  (aclk),
        .ctl   (lane_ctl),
        .coef  (coef0),
        .sample(samp0),
        .acc   (acc_even)
    );

    qmfs_lane #(
        .SAMPLE_BITS(SB),
        .COEF_BITS  (COEF_BITS),
        .ACC_W      (ACC_W)
    ) u_lane_odd (
        .aclk  (aclk),
        .ctl   (lane_ctl),
        .coef  (coef1),
        .sample(samp1),
        .acc   (acc_odd)
    );

    qmfs_merge #(
        .SAMPLE_BITS(SB),
        .COEF_BITS  (COEF_BITS),
        .ACC_W      (ACC_W)
    ) u_merge (
        .acc_even(acc_even),
        .acc_odd (acc_odd),
        .first   (first_w),
        .second  (second_w)
    );

`ifndef SYNTHESIS
    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == qmfs_pkg::ST_FIN)
        else $error("result beat raised outside the final stage");

    a_no_write_in_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_we |-> (state_reg == qmfs_pkg::ST_WR_SUM || state_reg == qmfs_pkg::ST_WR_DIFF))
        else $error("history written while the lanes are reading");

    a_drain_order: assert property (@(posedge aclk) disable iff (!aresetn)
        d2_reg |-> $past(d1_reg))
        else $error("accumulate enable without a preceding multiply");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(head_reg[sel_w]) < N)
        else $error("history write position out of range");
`endif

endmodule
